>>> rtl/assert_macros.svh
// assertion macros shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// property that must hold when enabled
`define CHK_ALWAYS(label, en, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (en) |-> (prop)) else $error(msg);
// consequence checked in the next cycle
`define CHK_NEXT(label, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) else $error(msg);
`endif

>>> rtl/sha256_pkg.sv
// types and constants for the sha-256 stream hasher
package sha256_pkg;
  typedef struct packed {
    logic [7:0] data_byte;
    logic       has_byte;
    logic       end_of_message;
  } in_item_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_LOAD, ST_ROUND, ST_UPDATE, ST_PAD, ST_EMIT
  } state_t;

  function automatic logic [31:0] init_h(input logic [2:0] i);
    case (i)
      3'd0: init_h = 32'h6a09e667;
      3'd1: init_h = 32'hbb67ae85;
      3'd2: init_h = 32'h3c6ef372;
      3'd3: init_h = 32'ha54ff53a;
      3'd4: init_h = 32'h510e527f;
      3'd5: init_h = 32'h9b05688c;
      3'd6: init_h = 32'h1f83d9ab;
      default: init_h = 32'h5be0cd19;
    endcase
  endfunction

  localparam logic [31:0] ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
    32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
    32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
    32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
    32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
    32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [7:0] PAD_BYTE = 8'h80;
  localparam logic [63:0] BLOCK_BITS = 64'd512;

  function automatic logic [31:0] ror(input logic [31:0] x, input int n);
    ror = (x >> n) | (x << (32 - n));
  endfunction
endpackage

>>> rtl/sha256_round.sv
// one sha-256 compression round; the message schedule word comes in as w_t
module sha256_round (
  input  logic [255:0] vars,
  input  logic [31:0]  w_t,
  input  logic [31:0]  k_t,
  output logic [255:0] vars_next
);
  import sha256_pkg::*;
  logic [31:0] a, b, c, d, e, f, g, h, t1, t2;
  always_comb begin
    {a, b, c, d, e, f, g, h} = vars;
    t1 = h + (ror(e, 6) ^ ror(e, 11) ^ ror(e, 25)) + ((e & f) ^ (~e & g)) + k_t + w_t;
    t2 = (ror(a, 2) ^ ror(a, 13) ^ ror(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
    vars_next = {t1 + t2, a, b, c, d + t1, e, f, g};
  end
endmodule

>>> rtl/sha256_stream_hasher_unit.sv
// top level of the sha-256 stream hasher
// usage
// - in channel: one transaction per message byte (has_byte) with end_of_message
//   marking the final transaction; a transaction with has_byte low carries no byte
// - out channel: eight transactions per message, digest words 0..7 with last_word on 7
// - bytes go into a 64 x 8 synchronous memory with a registered read
// - a full block triggers a compression: a load of 64 byte reads through the
//   registered memory read, 64 rounds and one update of the chaining words
// - a byte that does not fill a block or end the message is written and the block stays idle for the next byte
// - end mark: padding is written one byte per cycle from the fill position up to
//   byte 63 (all 64 bytes for a second block), a compression per block,
//   then eight output transactions, one per cycle while the receiver does not stall
// - the message schedule lives in a 16-word rolling window of registers
// - reset returns fill count, length and chaining words to their initial values;
//   the buffer memory is not cleared, every byte is written before it is read
// - when the receiver stalls, the current word holds and the block waits
// - in stalls while a compression, padding or digest output is in progress
module sha256_stream_hasher_unit (
  input  logic                  clk,
  input  logic                  rst,
  input  sha256_pkg::in_item_t  in_item,
  input  logic                  in_valid,
  output logic                  in_stall,
  output sha256_pkg::out_item_t out_item,
  output logic                  out_valid,
  input  logic                  out_stall
);
  import sha256_pkg::*;
  `include "assert_macros.svh"

  // block buffer memory
  logic [7:0] buf_mem [64];
  logic       mem_we;
  logic [5:0] mem_waddr, mem_raddr;
  logic [7:0] mem_wdata, mem_rdata;

  always_ff @(posedge clk) begin
    if (mem_we) buf_mem[mem_waddr] <= mem_wdata;
    mem_rdata <= buf_mem[mem_raddr];
  end

  state_t      state, state_next;
  logic [5:0]  fill_count;
  logic [63:0] bit_length;
  logic [31:0] chain [8];
  logic [255:0] vars;
  logic [31:0] win [16];
  logic [6:0]  cnt;       // load byte counter or round counter
  logic        finishing; // compression belongs to the end of a message
  logic        second;    // a second final compression is due
  logic [63:0] total;     // latched message length
  logic [5:0]  pad_ptr;
  logic [2:0]  emit_idx;
  logic [255:0] round_out;
  logic [31:0] w_now, s0, s1, w_new;

  logic in_acc, out_acc;
  assign in_acc  = in_valid && !in_stall;
  assign out_acc = out_valid && !out_stall;
  assign in_stall = (state != ST_IDLE);

  // schedule: window head is w[t]; new word for t+16
  assign w_now = win[0];
  assign s0 = ror(win[1], 7) ^ ror(win[1], 18) ^ (win[1] >> 3);
  assign s1 = ror(win[14], 17) ^ ror(win[14], 19) ^ (win[14] >> 10);
  assign w_new = s1 + win[9] + s0 + win[0];

  sha256_round u_round (
    .vars(vars), .w_t(w_now), .k_t(ROUND_K[cnt[5:0]]), .vars_next(round_out)
  );

  // padding byte for position pad_ptr
  // the marker follows the last byte; after a full final block it opens the padding block
  logic [7:0] pad_byte;
  always_comb begin
    if (pad_ptr == fill_count && (!second || fill_count < 6'd56)) pad_byte = PAD_BYTE;
    else if (pad_ptr >= 6'd56 && !(second == 1'b0 && fill_count >= 6'd56))
      pad_byte = total[8*(63 - 32'(pad_ptr)) +: 8];
    else pad_byte = 8'h00;
  end

  always_comb begin
    state_next = state;
    mem_we = 1'b0;
    mem_waddr = fill_count;
    mem_wdata = in_item.data_byte;
    mem_raddr = cnt[5:0];
    case (state)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_item.has_byte) begin
            mem_we = 1'b1;
            if (fill_count == 6'd63) state_next = ST_LOAD;
            else if (in_item.end_of_message) state_next = ST_PAD;
          end else if (in_item.end_of_message) state_next = ST_PAD;
        end
      end
      ST_PAD: begin
        mem_we = 1'b1;
        mem_waddr = pad_ptr;
        mem_wdata = pad_byte;
        if (pad_ptr == 6'd63) state_next = ST_LOAD;
      end
      ST_LOAD: if (cnt == 7'd64) state_next = ST_ROUND;
      ST_ROUND: if (cnt == 7'd63) state_next = ST_UPDATE;
      ST_UPDATE: begin
        if (!finishing) state_next = ST_IDLE;
        else if (second) state_next = ST_PAD;
        else state_next = ST_EMIT;
      end
      ST_EMIT: if (out_acc && emit_idx == 3'd7) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  assign out_valid = (state == ST_EMIT);
  assign out_item.digest_word = chain[emit_idx];
  assign out_item.word_index = emit_idx;
  assign out_item.last_word = (emit_idx == 3'd7);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      fill_count <= '0;
      bit_length <= '0;
      for (int i = 0; i < 8; i++) chain[i] <= init_h(3'(i));
      cnt <= '0;
      finishing <= 1'b0;
      second <= 1'b0;
      pad_ptr <= '0;
      emit_idx <= '0;
    end else begin
      state <= state_next;
      case (state)
        ST_IDLE: begin
          cnt <= '0;
          if (in_acc) begin
            if (in_item.has_byte) fill_count <= fill_count + 6'd1;
            if (in_item.has_byte && fill_count == 6'd63)
              bit_length <= bit_length + BLOCK_BITS;
            if (in_item.end_of_message) begin
              finishing <= 1'b1;
              // full block first, then a padding block from byte 0
              second <= in_item.has_byte && fill_count == 6'd63;
              if (in_item.has_byte) begin
                total <= bit_length + {54'd0, fill_count + 6'd1 == 6'd0 ? 7'd64 :
                         {1'b0, fill_count + 6'd1}, 3'd0};
                pad_ptr <= fill_count + 6'd1;
              end else begin
                total <= bit_length + {54'd0, 1'b0, fill_count, 3'd0};
                pad_ptr <= fill_count;
              end
            end
          end
        end
        ST_PAD: begin
          pad_ptr <= pad_ptr + 6'd1;
          if (pad_ptr == 6'd63) begin
            cnt <= '0;
            // two blocks needed when the marker left no room for the length
            if (!second && fill_count >= 6'd56) second <= 1'b1;
            else second <= 1'b0;
          end
        end
        ST_LOAD: begin
          // a read is issued at each count; its byte returns through the registered mem_rdata
          cnt <= (cnt == 7'd64) ? 7'd0 : cnt + 7'd1;
          if (cnt != 7'd0) begin
            // a new word starts every fourth byte
            if (cnt[1:0] == 2'd1) begin
              for (int i = 0; i < 15; i++) win[i] <= win[i + 1];
            end
            win[15] <= {win[15][23:0], mem_rdata};
          end
          for (int i = 0; i < 8; i++) vars[255 - 32*i -: 32] <= chain[i];
        end
        ST_ROUND: begin
          vars <= round_out;
          for (int i = 0; i < 15; i++) win[i] <= win[i + 1];
          win[15] <= w_new;
          cnt <= cnt + 7'd1;
        end
        ST_UPDATE: begin
          for (int i = 0; i < 8; i++) chain[i] <= chain[i] + vars[255 - 32*i -: 32];
          // the fill position is kept while a message finishes
          if (!finishing) fill_count <= '0;
          pad_ptr <= '0;
          emit_idx <= '0;
        end
        ST_EMIT: begin
          if (out_acc) begin
            emit_idx <= emit_idx + 3'd1;
            if (emit_idx == 3'd7) begin
              for (int i = 0; i < 8; i++) chain[i] <= init_h(3'(i));
              bit_length <= '0;
              fill_count <= '0;
              finishing <= 1'b0;
            end
          end
        end
        default: ;
      endcase
    end
  end

  `CHK_ALWAYS(a_no_in_when_busy, state != ST_IDLE, in_stall, "input taken while busy")
  `CHK_NEXT(a_emit_hold, out_valid && out_stall, out_valid && $stable(emit_idx),
            "digest word changed under stall")
  `CHK_NEXT(a_last_to_idle, out_acc && out_item.last_word, state == ST_IDLE,
            "block not idle after last word")
endmodule
